### src/gewb_pkg.sv
// Shared types, widths and codes for the grid edge weight builder.
package gewb_pkg;

	// Image and channel limits
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int CHANNEL_BITS = 16;

	// Fixed field widths of the ports
	localparam int IN_W     = 16;
	localparam int CFG_W    = 11;
	localparam int IDX_W    = 20;
	localparam int WEIGHT_W = 17;

	// Derived widths
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ROOT_W = CHANNEL_BITS + 1;
	localparam int SUM_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int CNT_W  = $clog2(ROOT_W);
	localparam int SQ_W   = 2 * CHANNEL_BITS;

	// Configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [2:0][CHANNEL_BITS-1:0] pixel_t;

	typedef enum logic [1:0] {
		EDGE_RIGHT     = 2'd0,
		EDGE_DOWN      = 2'd1,
		EDGE_DOWN_DIAG = 2'd2,
		EDGE_UP_DIAG   = 2'd3
	} edge_kind_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_READ_NEXT,
		OP_LATCH_UR,
		OP_DIFF,
		OP_SQUARE,
		OP_LOAD_ROOT,
		OP_ROOT_STEP,
		OP_EMIT,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		edge_kind_t kind;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] edge_mask;
		logic       out_free;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ_A,
		ST_READ_B,
		ST_DIFF,
		ST_SQUARE,
		ST_LOAD,
		ST_ROOT,
		ST_EMIT,
		ST_FINISH
	} ctl_state_t;

endpackage

### src/gewb_ctrl.sv
// Controller: sequences reads, edge selection, distance and square root steps.
module gewb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gewb_pkg::dp_status_t status,
	output gewb_pkg::dp_cmd_t   cmd
);
	import gewb_pkg::*;

	ctl_state_t        state_q, state_nxt;
	logic [3:0]        pending_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [3:0]        low_bit;
	logic [3:0]        remaining;
	edge_kind_t        cur_kind;

	// Lowest pending edge is the one in work
	assign low_bit   = pending_q & (~pending_q + 4'd1);
	assign remaining = pending_q & ~low_bit;

	always_comb begin
		if (pending_q[0]) begin
			cur_kind = EDGE_RIGHT;
		end else if (pending_q[1]) begin
			cur_kind = EDGE_DOWN;
		end else if (pending_q[2]) begin
			cur_kind = EDGE_DOWN_DIAG;
		end else begin
			cur_kind = EDGE_UP_DIAG;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_READ_A;
			end
			ST_READ_A: state_nxt = ST_READ_B;
			ST_READ_B: begin
				state_nxt = (status.edge_mask != 4'd0) ? ST_DIFF : ST_FINISH;
			end
			ST_DIFF:   state_nxt = ST_SQUARE;
			ST_SQUARE: state_nxt = ST_LOAD;
			ST_LOAD:   state_nxt = ST_ROOT;
			ST_ROOT: begin
				if (cnt_q == '0) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_nxt = (remaining != 4'd0) ? ST_DIFF : ST_FINISH;
				end
			end
			ST_FINISH: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall  = 1'b1;
		cmd.op    = OP_NONE;
		cmd.kind  = cur_kind;
		cmd.last  = (remaining == 4'd0);
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.op = OP_CAPTURE;
			end
			ST_READ_A: cmd.op = OP_READ_NEXT;
			ST_READ_B: cmd.op = OP_LATCH_UR;
			ST_DIFF:   cmd.op = OP_DIFF;
			ST_SQUARE: cmd.op = OP_SQUARE;
			ST_LOAD:   cmd.op = OP_LOAD_ROOT;
			ST_ROOT:   cmd.op = OP_ROOT_STEP;
			ST_EMIT: begin
				if (status.out_free) cmd.op = OP_EMIT;
			end
			ST_FINISH: cmd.op = OP_FINISH;
			default:   cmd.op = OP_NONE;
		endcase
	end

	// State, pending edges and root step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pending_q <= 4'd0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_READ_B) pending_q <= status.edge_mask;
			if (state_q == ST_EMIT && status.out_free) pending_q <= remaining;
			if (state_q == ST_LOAD) cnt_q <= CNT_W'(ROOT_W - 1);
			if (state_q == ST_ROOT) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### src/gewb_datapath.sv
// Datapath: pixel stores, position counters, distance, square root and output register.
module gewb_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [gewb_pkg::CFG_W-1:0]   cfg_data,
	input  logic [gewb_pkg::IN_W-1:0]    first_channel,
	input  logic [gewb_pkg::IN_W-1:0]    second_channel,
	input  logic [gewb_pkg::IN_W-1:0]    third_channel,
	input  gewb_pkg::dp_cmd_t            cmd,
	output gewb_pkg::dp_status_t         status,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [gewb_pkg::IDX_W-1:0]   from_index,
	output logic [gewb_pkg::IDX_W-1:0]   to_index,
	output logic [1:0]                   edge_kind,
	output logic [gewb_pkg::WEIGHT_W-1:0] weight,
	output logic                         last_edge
);
	import gewb_pkg::*;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] maxv);
		logic [CFG_W-1:0] r;
		begin
			r = v;
			if (v == '0) r = CFG_W'(1);
			else if (v > maxv) r = maxv;
			return r;
		end
	endfunction

	// Previous row store, one read and one write port
	pixel_t mem [MAX_WIDTH];
	pixel_t rd_data_q;
	logic   rd_en;
	logic [COL_W-1:0] rd_addr;

	// Configuration and position
	logic [CFG_W-1:0] w_q, h_q;
	logic [COL_W-1:0] x_q;
	logic [ROW_W-1:0] y_q;
	logic [IDX_W-1:0] here_q;
	logic [CFG_W:0]   x_next, y_next;
	logic             x_more, y_more;

	// Pixels of the current item
	pixel_t cur_q, left_q, above_q, above_left_q, upright_q;
	pixel_t cur_in, op_a;

	// Distance and root
	logic [2:0][CHANNEL_BITS-1:0] diff_q;
	logic [2:0][SQ_W-1:0]         sq_q;
	logic [SUM_W-1:0]             rad_q;
	logic [REM_W-1:0]             rem_q, rem_sh, trial;
	logic [ROOT_W-1:0]            root_q;
	logic                         root_ge;

	// Output register
	logic                out_valid_q;
	logic [IDX_W-1:0]    from_q, to_q, from_nxt, to_nxt;
	logic [IDX_W-1:0]    w_ext;
	edge_kind_t          kind_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                last_q;

	assign cur_in[0] = first_channel[CHANNEL_BITS-1:0];
	assign cur_in[1] = second_channel[CHANNEL_BITS-1:0];
	assign cur_in[2] = third_channel[CHANNEL_BITS-1:0];

	// Position tests
	assign x_next = (CFG_W+1)'(x_q) + 1'b1;
	assign y_next = (CFG_W+1)'(y_q) + 1'b1;
	assign x_more = x_next < {1'b0, w_q};
	assign y_more = y_next < {1'b0, h_q};

	assign status.edge_mask = {(y_q != '0) && x_more,
		(y_q != '0) && (x_q != '0),
		(y_q != '0),
		(x_q != '0)};
	assign status.out_free  = !out_valid_q || !out_stall;

	// Memory read address: above, then above-right
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = x_q;
		if (cmd.op == OP_CAPTURE) begin
			rd_en = 1'b1;
		end else if (cmd.op == OP_READ_NEXT) begin
			rd_en   = 1'b1;
			rd_addr = x_next[COL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
		if (cmd.op == OP_FINISH) mem[x_q] <= cur_q;
	end

	// Operand for the edge in work
	always_comb begin
		case (cmd.kind)
			EDGE_RIGHT:     op_a = left_q;
			EDGE_DOWN:      op_a = above_q;
			EDGE_DOWN_DIAG: op_a = above_left_q;
			default:        op_a = upright_q;
		endcase
	end

	// One square root digit per step
	assign rem_sh  = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
	assign trial   = REM_W'({root_q, 2'b01});
	assign root_ge = rem_sh >= trial;

	// Edge endpoints
	assign w_ext = IDX_W'(w_q);
	always_comb begin
		from_nxt = here_q;
		to_nxt   = here_q;
		case (cmd.kind)
			EDGE_RIGHT:     from_nxt = here_q - 1'b1;
			EDGE_DOWN:      from_nxt = here_q - w_ext;
			EDGE_DOWN_DIAG: from_nxt = here_q - w_ext - 1'b1;
			default:        to_nxt   = here_q - w_ext + 1'b1;
		endcase
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE:   cur_q   <= cur_in;
			OP_READ_NEXT: above_q <= rd_data_q;
			OP_LATCH_UR:  upright_q <= rd_data_q;
			OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					diff_q[i] <= (op_a[i] > cur_q[i]) ? op_a[i] - cur_q[i]
						: cur_q[i] - op_a[i];
				end
			end
			OP_SQUARE: begin
				for (int i = 0; i < 3; i++) begin
					sq_q[i] <= diff_q[i] * diff_q[i];
				end
			end
			OP_LOAD_ROOT: begin
				rad_q  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_ROOT_STEP: begin
				rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
				rem_q  <= root_ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], root_ge};
			end
			OP_EMIT: begin
				from_q   <= from_nxt;
				to_q     <= to_nxt;
				kind_q   <= cmd.kind;
				weight_q <= WEIGHT_W'(root_q);
				last_q   <= cmd.last;
			end
			OP_FINISH: begin
				left_q       <= cur_q;
				above_left_q <= above_q;
			end
			default: ;
		endcase
	end

	// Control state: configuration, position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= CFG_W'(MAX_WIDTH);
			h_q         <= CFG_W'(MAX_HEIGHT);
			x_q         <= '0;
			y_q         <= '0;
			here_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  w_q <= clamp_dim(cfg_data, CFG_W'(MAX_WIDTH));
					REG_HEIGHT: h_q <= clamp_dim(cfg_data, CFG_W'(MAX_HEIGHT));
					default: ;
				endcase
				x_q    <= '0;
				y_q    <= '0;
				here_q <= '0;
			end else if (cmd.op == OP_FINISH) begin
				if (x_more) begin
					x_q    <= x_next[COL_W-1:0];
					here_q <= here_q + 1'b1;
				end else if (y_more) begin
					x_q    <= '0;
					y_q    <= y_next[ROW_W-1:0];
					here_q <= here_q + 1'b1;
				end else begin
					x_q    <= '0;
					y_q    <= '0;
					here_q <= '0;
				end
			end
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign from_index = from_q;
	assign to_index   = to_q;
	assign edge_kind  = kind_q;
	assign weight     = weight_q;
	assign last_edge  = last_q;

endmodule

### src/grid_edge_weight_builder_top.sv
// Top level of the grid edge weight builder: controller, datapath and checks.
//
// Pixels arrive in raster order on the input channel (in_valid / in_stall),
// three unsigned channels per item. For each pixel the block sends the edges
// of the 8-connected grid graph that link it to earlier pixels: right, down,
// down-right, up-right, in that order and only those that exist, each with
// both raster indices, its kind and the floored color distance. last_edge
// marks the final edge of a pixel; the first pixel of an image sends none.
// Each item is captured, its row is read, and then for each edge come the
// difference, square and sum steps, the square root unit, which resolves one
// result bit per cycle over 17 steps, and the output step.
// The previous row lives in a single-port-read memory read twice per item.
// A result waits in the output register while the receiver stalls; the block
// stops in its output step until that register is free. The next item is
// accepted while the last result of the previous one still waits.
// Reset sets width and height to 1024 and starts at row 0, column 0. A write
// to either register restarts the image; write only while the block is idle.
module grid_edge_weight_builder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [gewb_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gewb_pkg::IN_W-1:0]     first_channel,
	input  logic [gewb_pkg::IN_W-1:0]     second_channel,
	input  logic [gewb_pkg::IN_W-1:0]     third_channel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gewb_pkg::IDX_W-1:0]    from_index,
	output logic [gewb_pkg::IDX_W-1:0]    to_index,
	output logic [1:0]                    edge_kind,
	output logic [gewb_pkg::WEIGHT_W-1:0] weight,
	output logic                          last_edge
);
	import gewb_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	gewb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	gewb_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.first_channel  (first_channel),
		.second_channel (second_channel),
		.third_channel  (third_channel),
		.cmd            (cmd),
		.status         (status),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.from_index     (from_index),
		.to_index       (to_index),
		.edge_kind      (edge_kind),
		.weight         (weight),
		.last_edge      (last_edge)
	);

	// An edge is loaded only when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> status.out_free)
		else $error("edge loaded over a pending result");

	// An accepted pixel issues its second row read in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> cmd.op == OP_READ_NEXT)
		else $error("row read did not follow an accepted item");

	// The final edge of a pixel is followed by the state update
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT && cmd.last) |=> cmd.op == OP_FINISH)
		else $error("final edge not followed by the update step");

	// A loaded edge is shown on the output in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |=> out_valid)
		else $error("loaded edge not presented");

endmodule

### sim/gewb_edge_checker.sv
// Edge checker: predicts the grid edges of every accepted pixel and compares the output items.
module gewb_edge_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [gewb_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [gewb_pkg::IN_W-1:0]     first_channel,
	input  logic [gewb_pkg::IN_W-1:0]     second_channel,
	input  logic [gewb_pkg::IN_W-1:0]     third_channel,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [gewb_pkg::IDX_W-1:0]    from_index,
	input  logic [gewb_pkg::IDX_W-1:0]    to_index,
	input  logic [1:0]                    edge_kind,
	input  logic [gewb_pkg::WEIGHT_W-1:0] weight,
	input  logic                          last_edge,
	output int                            fail_count,
	output int                            pending,
	output int                            edges_checked
);
	import gewb_pkg::*;

	// Printing stops after this many errors; counting goes on
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [IDX_W-1:0]    from_idx;
		logic [IDX_W-1:0]    to_idx;
		edge_kind_t          kind;
		logic [WEIGHT_W-1:0] wt;
		logic                last;
	} edge_rec_t;

	// Predictor state
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	pixel_t           left_px;
	pixel_t           above_left_px;
	pixel_t           line_buf [MAX_WIDTH];
	edge_rec_t        due_edges [$];

	task automatic report(input string field, input longint unsigned got,
			input longint unsigned want);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("ERROR at %0t: %s is %0d, predicted %0d", $time, field, got, want);
	endtask

	function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int maxv);
		if (v == 0)
			return CFG_W'(1);
		if (v > maxv)
			return CFG_W'(maxv);
		return v;
	endfunction

	// Floor of the Euclidean color distance; float root, then corrected to exact
	function automatic logic [WEIGHT_W-1:0] floor_distance(pixel_t a, pixel_t b);
		longint unsigned acc;
		longint unsigned d;
		longint unsigned r;
		acc = 0;
		for (int c = 0; c < 3; c++) begin
			d = (a[c] > b[c]) ? a[c] - b[c] : b[c] - a[c];
			acc += d * d;
		end
		r = longint'($sqrt(real'(acc)));
		while (r * r > acc)
			r--;
		while ((r + 1) * (r + 1) <= acc)
			r++;
		return r[WEIGHT_W-1:0];
	endfunction

	function automatic edge_rec_t make_edge(logic [IDX_W-1:0] f, logic [IDX_W-1:0] t,
			edge_kind_t k, logic [WEIGHT_W-1:0] w);
		edge_rec_t e;
		e.from_idx = f;
		e.to_idx   = t;
		e.kind     = k;
		e.wt       = w;
		e.last     = 1'b0;
		return e;
	endfunction

	// Edges linking the arriving pixel to earlier pixels, in right, down, down-right, up-right order
	task automatic derive_edges(input pixel_t cur);
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [IDX_W-1:0] wd;
		logic [IDX_W-1:0] here;
		pixel_t           above;
		edge_rec_t        found [4];
		int               n;
		w     = clamp_dim(width_reg, MAX_WIDTH);
		h     = clamp_dim(height_reg, MAX_HEIGHT);
		wd    = IDX_W'(w);
		here  = row * wd + col;
		above = line_buf[col];
		n     = 0;
		if (col != 0) begin
			found[n] = make_edge(here - 1'b1, here, EDGE_RIGHT,
				floor_distance(left_px, cur));
			n++;
		end
		if (row != 0) begin
			found[n] = make_edge(here - wd, here, EDGE_DOWN, floor_distance(above, cur));
			n++;
			if (col != 0) begin
				found[n] = make_edge(here - wd - 1'b1, here, EDGE_DOWN_DIAG,
					floor_distance(above_left_px, cur));
				n++;
			end
			if (CFG_W'(col) + 1'b1 < w) begin
				found[n] = make_edge(here, here - wd + 1'b1, EDGE_UP_DIAG,
					floor_distance(cur, line_buf[col + 1'b1]));
				n++;
			end
		end
		if (n > 0)
			found[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			due_edges.push_back(found[i]);

		above_left_px = above;
		line_buf[col] = cur;
		left_px       = cur;

		// Raster advance, wrapping to a new image after the last pixel
		if (CFG_W'(col) + 1'b1 < w) begin
			col = col + 1'b1;
		end else begin
			col = '0;
			row = (CFG_W'(row) + 1'b1 < h) ? row + 1'b1 : '0;
		end
	endtask

	task automatic check_edge();
		edge_rec_t e;
		edges_checked++;
		if (due_edges.size() == 0) begin
			report("edge with none due, from_index", from_index, 0);
		end else begin
			e = due_edges.pop_front();
			if (from_index !== e.from_idx)
				report("from_index", from_index, e.from_idx);
			if (to_index !== e.to_idx)
				report("to_index", to_index, e.to_idx);
			if (edge_kind !== e.kind)
				report("edge_kind", edge_kind, e.kind);
			if (weight !== e.wt)
				report("weight", weight, e.wt);
			if (last_edge !== e.last)
				report("last_edge", last_edge, e.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg     = 11'd1024;
			height_reg    = 11'd1024;
			col           = '0;
			row           = '0;
			left_px       = '0;
			above_left_px = '0;
			for (int i = 0; i < MAX_WIDTH; i++)
				line_buf[i] = '0;
			due_edges.delete();
			fail_count    = 0;
			edges_checked = 0;
			pending      <= 0;
		end else begin
			// A register write restarts the image
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
				col = '0;
				row = '0;
			end
			if (out_valid && !out_stall)
				check_edge();
			if (in_valid && !in_stall)
				derive_edges({third_channel[CHANNEL_BITS-1:0], second_channel[CHANNEL_BITS-1:0],
					first_channel[CHANNEL_BITS-1:0]});
			pending <= due_edges.size();
		end
	end

endmodule

### sim/grid_edge_weight_builder_top_tb.sv
// Testbench top: pixel stimulus, output stall pattern, watchdog and verdict.
module grid_edge_weight_builder_top_tb;
	import gewb_pkg::*;

	localparam int QUIET_LIMIT   = 6000;  // cycles with no item moved and no register write
	localparam int HOLD_CYCLES   = 400;   // long output hold-off
	localparam int SETTLE_CYCLES = 100;   // margin beyond the longest item
	localparam int PHASES        = 12;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                cfg_we         = 1'b0;
	logic                cfg_index      = 1'b0;
	logic [CFG_W-1:0]    cfg_data       = '0;
	logic                in_valid       = 1'b0;
	logic [IN_W-1:0]     first_channel  = '0;
	logic [IN_W-1:0]     second_channel = '0;
	logic [IN_W-1:0]     third_channel  = '0;
	logic                out_stall      = 1'b0;
	logic                in_stall;
	logic                out_valid;
	logic [IDX_W-1:0]    from_index;
	logic [IDX_W-1:0]    to_index;
	logic [1:0]          edge_kind;
	logic [WEIGHT_W-1:0] weight;
	logic                last_edge;

	int send_idle_pct = 37;
	int recv_idle_pct = 68;
	int holds_asked   = 0;
	int holds_given   = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int pixels_sent   = 0;
	int settings_used = 0;
	int fail_count;
	int pending;
	int edges_checked;

	always #1 clk = ~clk;

	grid_edge_weight_builder_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.first_channel  (first_channel),
		.second_channel (second_channel),
		.third_channel  (third_channel),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.from_index     (from_index),
		.to_index       (to_index),
		.edge_kind      (edge_kind),
		.weight         (weight),
		.last_edge      (last_edge)
	);

	gewb_edge_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.first_channel  (first_channel),
		.second_channel (second_channel),
		.third_channel  (third_channel),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.from_index     (from_index),
		.to_index       (to_index),
		.edge_kind      (edge_kind),
		.weight         (weight),
		.last_edge      (last_edge),
		.fail_count     (fail_count),
		.pending        (pending),
		.edges_checked  (edges_checked)
	);

	// Receiver: random stall, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_given != holds_asked) begin
			out_stall   <= 1'b1;
			hold_left   <= HOLD_CYCLES;
			holds_given <= holds_given + 1;
		end else begin
			out_stall <= (int'($urandom_range(99)) < recv_idle_pct);
		end
	end

	// Watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Offer one pixel, with a random gap first, and wait until it is taken
	task automatic send_pixel(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
			input logic [IN_W-1:0] c);
		if (int'($urandom_range(99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while (int'($urandom_range(99)) < send_idle_pct);
		end
		in_valid       <= 1'b1;
		first_channel  <= a;
		second_channel <= b;
		third_channel  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_sent++;
	endtask

	// Stop sending until every predicted edge is out, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_image(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		settings_used++;
	endtask

	function automatic logic [IN_W-1:0] rand_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return IN_W'($urandom_range(15));
			default: return IN_W'($urandom);
		endcase
	endfunction

	// Mostly small sizes; now and then zero, one, the maximum or past it
	function automatic logic [CFG_W-1:0] pick_dim();
		case ($urandom_range(15))
			0: return '0;
			1: return 11'd1;
			2: return 11'd2047;
			3: return 11'd1024;
			default: return CFG_W'($urandom_range(2, 9));
		endcase
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size: first row, right edges only, extreme weights
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h0000, 16'hFFFF, 16'h0000);
		settle();

		// 3x3 image: all four kinds, then wrap into a new image
		program_image(11'd3, 11'd3);
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
		send_pixel(16'h0000, 16'hFFFF, 16'h0000);
		send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
		send_pixel(16'h0000, 16'h0000, 16'hFFFF);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'h1234, 16'h5678, 16'h9ABC);
		settle();

		// Width zero acts as one column, height past the maximum clamps
		program_image(11'd0, 11'd2047);
		send_pixel(16'hFFFF, 16'h0000, 16'h0000);
		send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
		send_pixel(16'hA5A5, 16'h5A5A, 16'h0F0F);
		send_pixel(16'h5A5A, 16'hA5A5, 16'hF0F0);
		settle();

		// Width past the maximum, height zero acts as one row
		program_image(11'd2047, 11'd0);
		send_pixel(16'h8000, 16'h0001, 16'h7FFF);
		send_pixel(16'h0001, 16'h8000, 16'h8000);
		send_pixel(16'hFFFF, 16'hFFFE, 16'h0000);
		send_pixel(16'h0000, 16'h0001, 16'hFFFF);

		// Random images under three idle mixes
		for (int p = 0; p < PHASES; p++) begin
			int items;
			if (p < PHASES / 3) begin
				send_idle_pct = 37;
				recv_idle_pct = 68;
			end else if (p < 2 * PHASES / 3) begin
				send_idle_pct = 68;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			settle();
			if ($urandom_range(3) == 0) begin
				write_reg(REG_HEIGHT, pick_dim());
				settings_used++;
			end else begin
				program_image(pick_dim(), pick_dim());
			end
			items = $urandom_range(20, 40);
			for (int i = 0; i < items; i++) begin
				// Output held off while pixels keep coming, so the input backs up
				if (i == 5 && (p == 2 || p == 9))
					holds_asked++;
				if (i == items / 2 && p == 5)
					settle();
				send_pixel(rand_channel(), rand_channel(), rand_channel());
			end
		end

		settle();
		$display("Run covered %0d pixels and %0d edges over %0d image settings,",
			pixels_sent, edges_checked, settings_used);
		$display("with idle and stall mixes on both channels and long output hold-offs.");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
